// ===== rtl/core/sstc_pkg.sv =====
// ----------------------------------------------------------------------------
// sstc_pkg
// Shared types and constants for the sparse spectrum tone classifier.
// ----------------------------------------------------------------------------
package sstc_pkg;

  localparam int BINS_DEF   = 64;

  localparam int LEVEL_W    = 32;
  localparam int DELTA_W    = 16;
  localparam int TOTAL_W    = 38;
  localparam int FRAC_W     = 16;
  localparam int DTHR_W     = 15;
  localparam int LIMIT_W    = 7;
  localparam int ACT_W      = 7;
  localparam int BAND_W     = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FRACTION      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNIFICANT_FRACTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_THRESHOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LIMIT         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SHARE           = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP4_SHARE           = 3'd5;

  localparam logic [FRAC_W-1:0]  RST_ACTIVE_FRACTION      = 16'd9830;
  localparam logic [FRAC_W-1:0]  RST_SIGNIFICANT_FRACTION = 16'd11796;
  localparam logic [DTHR_W-1:0]  RST_DELTA_THRESHOLD      = 15'd256;
  localparam logic [LIMIT_W-1:0] RST_ACTIVE_LIMIT         = 7'd18;
  localparam logic [FRAC_W-1:0]  RST_PEAK_SHARE           = 16'd14418;
  localparam logic [FRAC_W-1:0]  RST_TOP4_SHARE           = 16'd39322;

  // 1.0e-6 and 1.0 in unsigned Q8.24
  localparam logic [LEVEL_W-1:0] SILENT_LIMIT = 32'd16;
  localparam logic [TOTAL_W-1:0] UNIT_Q824    = 38'd16777216;

  typedef enum logic [1:0] {
    OUT_SUMMARY,
    OUT_BAND,
    OUT_SILENT
  } out_kind_e;

  typedef struct packed {
    logic      acc;
    logic      clr_stats;
    logic      calc;
    logic      idx_clr;
    logic      idx_inc;
    logic      rd;
    logic      count_chk;
    logic      decide;
    logic      load_out;
    out_kind_e out_kind;
  } cmd_t;

  typedef struct packed {
    logic silent;
    logic idx_end;
    logic sig_hit;
    logic sparse;
    logic no_sig;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/sstc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sstc_ctrl
// Sequencer: bin intake, threshold setup, count pass, decision, emit pass or summary.
// ----------------------------------------------------------------------------
module sstc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_final_i,
  output logic          in_ready_o,
  input  sstc_pkg::sts_t sts_i,
  output sstc_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_ACCUM,
    S_CALC,
    S_CNT_RD,
    S_CNT_CHK,
    S_DECIDE,
    S_EMIT_RD,
    S_EMIT_CHK,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_kind = sstc_pkg::OUT_SUMMARY;
    in_ready_o = 1'b0;
    case (state_q)
      S_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_final_i) state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (sts_i.silent) begin
          if (sts_i.out_free) begin
            cmd_o.load_out  = 1'b1;
            cmd_o.out_kind  = sstc_pkg::OUT_SILENT;
            cmd_o.clr_stats = 1'b1;
            state_d         = S_ACCUM;
          end
        end else begin
          cmd_o.calc    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CNT_CHK;
      end
      S_CNT_CHK: begin
        cmd_o.count_chk = 1'b1;
        if (sts_i.idx_end) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_DECIDE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_CNT_RD;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (sts_i.sparse && !sts_i.no_sig) state_d = S_EMIT_RD;
        else state_d = S_FINISH;
      end
      S_EMIT_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        if (!sts_i.sig_hit || sts_i.out_free) begin
          if (sts_i.sig_hit) begin
            cmd_o.load_out = 1'b1;
            cmd_o.out_kind = sstc_pkg::OUT_BAND;
          end
          if (sts_i.idx_end) begin
            cmd_o.clr_stats = 1'b1;
            state_d         = S_ACCUM;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_EMIT_RD;
          end
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.out_kind  = sstc_pkg::OUT_SUMMARY;
          cmd_o.clr_stats = 1'b1;
          state_d         = S_ACCUM;
        end
      end
      default: begin
        state_d = S_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/sstc_dp.sv =====
// ----------------------------------------------------------------------------
// sstc_dp
// Datapath: settings, bin memory, spectrum statistics, share tests, result.
// ----------------------------------------------------------------------------
module sstc_dp #(
  parameter int BINS = sstc_pkg::BINS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sstc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sstc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [sstc_pkg::LEVEL_W-1:0]       in_before_i,
  input  logic [sstc_pkg::LEVEL_W-1:0]       in_after_i,
  input  logic signed [sstc_pkg::DELTA_W-1:0] in_delta_i,
  input  sstc_pkg::cmd_t                     cmd_i,
  output sstc_pkg::sts_t                     sts_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_is_sparse_o,
  output logic [sstc_pkg::ACT_W-1:0]         out_active_count_o,
  output logic [sstc_pkg::BAND_W-1:0]        out_band_index_o,
  output logic                               out_band_valid_o,
  output logic                               out_last_o
);

  localparam int AW     = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int CW     = $clog2(BINS + 1);
  localparam int LevelW = sstc_pkg::LEVEL_W;
  localparam int TotalW = sstc_pkg::TOTAL_W;
  localparam int FracW  = sstc_pkg::FRAC_W;
  localparam int ThrW   = LevelW + FracW;
  localparam int ShrW   = TotalW + FracW;
  localparam int Sum4W  = LevelW + 2;
  localparam int ActW   = sstc_pkg::ACT_W;
  localparam int BandW  = sstc_pkg::BAND_W;
  localparam int MagW   = sstc_pkg::DELTA_W + 1;
  localparam int DthrW  = sstc_pkg::DTHR_W;
  localparam int LimitW = sstc_pkg::LIMIT_W;
  localparam logic [CW-1:0] BinsC = CW'(BINS);

  // settings
  logic [FracW-1:0]  af_q, sf_q, pst_q, tst_q;
  logic [DthrW-1:0]  dthr_q;
  logic [LimitW-1:0] alim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q   <= sstc_pkg::RST_ACTIVE_FRACTION;
      sf_q   <= sstc_pkg::RST_SIGNIFICANT_FRACTION;
      dthr_q <= sstc_pkg::RST_DELTA_THRESHOLD;
      alim_q <= sstc_pkg::RST_ACTIVE_LIMIT;
      pst_q  <= sstc_pkg::RST_PEAK_SHARE;
      tst_q  <= sstc_pkg::RST_TOP4_SHARE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sstc_pkg::CFG_ACTIVE_FRACTION:      af_q   <= cfg_data_i;
        sstc_pkg::CFG_SIGNIFICANT_FRACTION: sf_q   <= cfg_data_i;
        sstc_pkg::CFG_DELTA_THRESHOLD:      dthr_q <= cfg_data_i[DthrW-1:0];
        sstc_pkg::CFG_ACTIVE_LIMIT:         alim_q <= cfg_data_i[LimitW-1:0];
        sstc_pkg::CFG_PEAK_SHARE:           pst_q  <= cfg_data_i;
        sstc_pkg::CFG_TOP4_SHARE:           tst_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // bin intake
  logic [LevelW-1:0] energy;
  logic [MagW-1:0]   mag;
  logic              dflag;
  logic              store_en;
  logic [CW-1:0]     cnt_q;
  logic [LevelW-1:0] max_q;
  logic [TotalW-1:0] total_q;
  logic [LevelW-1:0] top_q [4];
  logic [LevelW-1:0] top_d [4];

  assign energy   = (in_before_i > in_after_i) ? in_before_i : in_after_i;
  assign mag      = in_delta_i[sstc_pkg::DELTA_W-1]
                  ? (MagW'(17'h10000) - {1'b0, in_delta_i})
                  : {1'b0, in_delta_i};
  assign dflag    = mag >= MagW'(dthr_q);
  assign store_en = cmd_i.acc && (cnt_q < BinsC);

  always_comb begin
    top_d = top_q;
    if (energy > top_q[0]) begin
      top_d[3] = top_q[2];
      top_d[2] = top_q[1];
      top_d[1] = top_q[0];
      top_d[0] = energy;
    end else if (energy > top_q[1]) begin
      top_d[3] = top_q[2];
      top_d[2] = top_q[1];
      top_d[1] = energy;
    end else if (energy > top_q[2]) begin
      top_d[3] = top_q[2];
      top_d[2] = energy;
    end else if (energy > top_q[3]) begin
      top_d[3] = energy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      max_q   <= '0;
      total_q <= '0;
      top_q   <= '{default: '0};
    end else if (cmd_i.clr_stats) begin
      cnt_q   <= '0;
      max_q   <= '0;
      total_q <= '0;
      top_q   <= '{default: '0};
    end else if (store_en) begin
      cnt_q   <= cnt_q + CW'(1);
      if (energy > max_q) max_q <= energy;
      total_q <= total_q + TotalW'(energy);
      top_q   <= top_d;
    end
  end

  // bin memory: {delta flag, energy}
  logic [LevelW:0] mem [BINS];
  logic [LevelW:0] rd_q;
  logic [AW-1:0]   idx_q;

  always_ff @(posedge clk_i) begin
    if (store_en) mem[cnt_q[AW-1:0]] <= {dflag, energy};
    if (cmd_i.rd) rd_q <= mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + AW'(1);
    end
  end

  // thresholds and share terms
  logic [ThrW-1:0]   thr_act_q, thr_sig_q;
  logic [ShrW-1:0]   peak_rhs_q, top4_rhs_q;
  logic [Sum4W-1:0]  sum4_q;
  logic [TotalW-1:0] denom;

  assign denom = (total_q > sstc_pkg::UNIT_Q824) ? total_q : sstc_pkg::UNIT_Q824;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      thr_act_q  <= ThrW'(af_q) * ThrW'(max_q);
      thr_sig_q  <= ThrW'(sf_q) * ThrW'(max_q);
      peak_rhs_q <= ShrW'(pst_q) * ShrW'(total_q);
      top4_rhs_q <= ShrW'(tst_q) * ShrW'(denom);
      sum4_q     <= Sum4W'(top_q[0]) + Sum4W'(top_q[1])
                  + Sum4W'(top_q[2]) + Sum4W'(top_q[3]);
    end
  end

  // per-bin tests
  logic [ThrW-1:0] rd_scaled;
  logic            act_hit, sig_hit;
  logic [CW-1:0]   act_cnt_q, sig_cnt_q, rem_q;
  logic            sparse_now, sparse_q;

  assign rd_scaled = {rd_q[LevelW-1:0], {FracW{1'b0}}};
  assign act_hit   = rd_scaled >= thr_act_q;
  assign sig_hit   = (rd_scaled >= thr_sig_q) || rd_q[LevelW];

  assign sparse_now = (ActW'(act_cnt_q) <= alim_q)
                   || (ShrW'({top_q[0], {FracW{1'b0}}}) >= peak_rhs_q)
                   || (ShrW'({sum4_q, {FracW{1'b0}}}) >= top4_rhs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      act_cnt_q <= '0;
      sig_cnt_q <= '0;
    end else if (cmd_i.count_chk) begin
      if (act_hit) act_cnt_q <= act_cnt_q + CW'(1);
      if (sig_hit) sig_cnt_q <= sig_cnt_q + CW'(1);
    end
    if (cmd_i.decide) begin
      sparse_q <= sparse_now;
      rem_q    <= sig_cnt_q;
    end else if (cmd_i.load_out && cmd_i.out_kind == sstc_pkg::OUT_BAND) begin
      rem_q <= rem_q - CW'(1);
    end
  end

  // result register
  logic out_free;

  assign out_free = !out_valid_o || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (cmd_i.out_kind)
        sstc_pkg::OUT_BAND: begin
          out_is_sparse_o    <= 1'b1;
          out_active_count_o <= ActW'(act_cnt_q);
          out_band_index_o   <= BandW'(idx_q);
          out_band_valid_o   <= 1'b1;
          out_last_o         <= rem_q == CW'(1);
        end
        sstc_pkg::OUT_SILENT: begin
          out_is_sparse_o    <= 1'b0;
          out_active_count_o <= '0;
          out_band_index_o   <= '0;
          out_band_valid_o   <= 1'b0;
          out_last_o         <= 1'b1;
        end
        default: begin
          out_is_sparse_o    <= sparse_q;
          out_active_count_o <= ActW'(act_cnt_q);
          out_band_index_o   <= '0;
          out_band_valid_o   <= 1'b0;
          out_last_o         <= 1'b1;
        end
      endcase
    end
  end

  assign sts_o.silent   = max_q <= sstc_pkg::SILENT_LIMIT;
  assign sts_o.idx_end  = (CW'(idx_q) + CW'(1)) == cnt_q;
  assign sts_o.sig_hit  = sig_hit;
  assign sts_o.sparse   = sparse_now;
  assign sts_o.no_sig   = sig_cnt_q == '0;
  assign sts_o.out_free = out_free;

endmodule

// ===== rtl/core/sparse_spectrum_tone_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_spectrum_tone_classifier_unit
// Sorts a spectrum into sparse tonal or not, and lists its significant bands.
// ----------------------------------------------------------------------------
// Bins stream in at one per clock and are stored in a BINS-deep bin memory
// while peak, total and top-four energies update on the fly. After the bin
// marked tlast the input is held off while the spectrum is classified: a
// setup step, a count pass that reads and checks each stored bin in turn
// through the single read port of the bin memory, a decision step, then
// either an emit pass over the stored bins for a sparse spectrum with
// significant bands or a summary step. A silent spectrum finishes in the
// setup step. Each result waits while the result stream stalls. The next
// spectrum is taken once the last result is in the output register.
// ----------------------------------------------------------------------------
module sparse_spectrum_tone_classifier_unit #(
  parameter int BINS = sstc_pkg::BINS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sstc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sstc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // before_level [31:0], after_level [63:32], delta_db [79:64]
  input  logic [79:0]                     s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // is_sparse [0], active_count [7:1], band_index [13:8], band_valid [14]
  output logic [15:0]                     m_axis_tdata,
  output logic                            m_axis_tlast
);

  sstc_pkg::cmd_t cmd;
  sstc_pkg::sts_t sts;

  logic                           is_sparse;
  logic [sstc_pkg::ACT_W-1:0]     active_count;
  logic [sstc_pkg::BAND_W-1:0]    band_index;
  logic                           band_valid;

  sstc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_final_i (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sstc_dp #(
    .BINS (BINS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_before_i        (s_axis_tdata[31:0]),
    .in_after_i         (s_axis_tdata[63:32]),
    .in_delta_i         (s_axis_tdata[79:64]),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .out_is_sparse_o    (is_sparse),
    .out_active_count_o (active_count),
    .out_band_index_o   (band_index),
    .out_band_valid_o   (band_valid),
    .out_last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, band_valid, band_index, active_count, is_sparse};

  a_no_load_in_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.load_out)
    else $error("result loaded during bin intake");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("pending result overwritten");

  a_check_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.count_chk |-> $past(cmd.rd))
    else $error("count check without memory read");

endmodule

// ===== bench/tb_sparse_spectrum_tone_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sparse_spectrum_tone_classifier_unit
// Self-checking bench for the sparse spectrum tone classifier.
// ----------------------------------------------------------------------------
// Streams spectra of random shape and length into the block. A scoreboard
// class keeps its own copy of the bin store, peak, total and top-four energies.
// It classifies each spectrum when the final bin is taken and queues the band
// or summary reports that should come out. Each report taken from the result
// stream is compared field by field with the oldest queued one. Several register settings
// are used, including all-zero and all-max save an active limit of 64. Both
// sides idle at random, and one long result stall backs the block up.
// ----------------------------------------------------------------------------
module tb_sparse_spectrum_tone_classifier_unit;

  localparam int BINS         = sstc_pkg::BINS_DEF;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int TARGET_BINS  = 380;

  typedef enum {SHAPE_TONAL, SHAPE_FLAT, SHAPE_WILD, SHAPE_SILENT} shape_e;

  typedef struct {
    bit       sparse;
    bit [6:0] count;
    bit [5:0] band;
    bit       valid;
    bit       last;
  } band_report_t;

  class spectrum_scoreboard;
    bit [15:0] act_frac;
    bit [15:0] sig_frac;
    bit [14:0] delta_thr;
    bit [6:0]  act_limit;
    bit [15:0] peak_share;
    bit [15:0] top4_share;

    bit [31:0] energy[BINS];
    bit        delta_hit[BINS];
    bit [31:0] peak;
    bit [37:0] total;
    bit [31:0] top[4];
    int unsigned bins_held;
    bit        overflowed;

    band_report_t expected_reports[$];

    int unsigned failures;
    int unsigned reports_checked;
    int unsigned spectra, silent_seen, sparse_seen, dense_seen, overlong_seen;

    function new();
      act_frac   = sstc_pkg::RST_ACTIVE_FRACTION;
      sig_frac   = sstc_pkg::RST_SIGNIFICANT_FRACTION;
      delta_thr  = sstc_pkg::RST_DELTA_THRESHOLD;
      act_limit  = sstc_pkg::RST_ACTIVE_LIMIT;
      peak_share = sstc_pkg::RST_PEAK_SHARE;
      top4_share = sstc_pkg::RST_TOP4_SHARE;
      clear_spectrum();
    endfunction

    function void clear_spectrum();
      peak = '0;
      total = '0;
      for (int s = 0; s < 4; s++) top[s] = '0;
      bins_held = 0;
      overflowed = 1'b0;
    endfunction

    function void set_reg(logic [sstc_pkg::CFG_IDX_W-1:0] idx,
                          logic [sstc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        sstc_pkg::CFG_ACTIVE_FRACTION:      act_frac   = val;
        sstc_pkg::CFG_SIGNIFICANT_FRACTION: sig_frac   = val;
        sstc_pkg::CFG_DELTA_THRESHOLD:      delta_thr  = val[sstc_pkg::DTHR_W-1:0];
        sstc_pkg::CFG_ACTIVE_LIMIT:         act_limit  = val[sstc_pkg::LIMIT_W-1:0];
        sstc_pkg::CFG_PEAK_SHARE:           peak_share = val;
        sstc_pkg::CFG_TOP4_SHARE:           top4_share = val;
        default: ;
      endcase
    endfunction

    function void queue_report(bit sparse, bit [6:0] count, bit [5:0] band, bit valid,
                               bit last);
      band_report_t r;
      r.sparse = sparse;
      r.count  = count;
      r.band   = band;
      r.valid  = valid;
      r.last   = last;
      expected_reports.insert(expected_reports.size(), r);
    endfunction

    function void note_bin(bit [31:0] pre_level, bit [31:0] post_level, bit [15:0] delta,
                           bit final_bin);
      bit [31:0] e;
      bit [16:0] mag;
      longint unsigned sum4, denom;
      int unsigned active, hits;
      bit sparse;
      e   = (pre_level > post_level) ? pre_level : post_level;
      mag = delta[15] ? (17'h10000 - {1'b0, delta}) : {1'b0, delta};
      if (bins_held < BINS) begin
        energy[bins_held]    = e;
        delta_hit[bins_held] = (mag >= {2'b00, delta_thr});
        if (e > peak) peak = e;
        total += 38'(e);
        for (int s = 0; s < 4; s++) begin
          if (e > top[s]) begin
            for (int m = 3; m > s; m--) top[m] = top[m-1];
            top[s] = e;
            break;
          end
        end
        bins_held++;
      end else begin
        overflowed = 1'b1;
      end
      if (!final_bin) return;

      spectra++;
      if (overflowed) overlong_seen++;
      if (peak <= sstc_pkg::SILENT_LIMIT) begin
        silent_seen++;
        queue_report(1'b0, 7'd0, 6'd0, 1'b0, 1'b1);
        clear_spectrum();
        return;
      end

      active = 0;
      for (int i = 0; i < bins_held; i++)
        if ((64'(energy[i]) << 16) >= 64'(act_frac) * 64'(peak)) active++;
      sum4  = 64'(top[0]) + 64'(top[1]) + 64'(top[2]) + 64'(top[3]);
      denom = (total > sstc_pkg::UNIT_Q824) ? 64'(total) : 64'(sstc_pkg::UNIT_Q824);
      sparse = (active <= act_limit)
            || ((64'(top[0]) << 16) >= 64'(peak_share) * 64'(total))
            || ((sum4 << 16) >= 64'(top4_share) * denom);

      hits = 0;
      if (sparse) begin
        sparse_seen++;
        for (int i = 0; i < bins_held; i++) begin
          if (((64'(energy[i]) << 16) >= 64'(sig_frac) * 64'(peak)) || delta_hit[i]) begin
            queue_report(1'b1, 7'(active), 6'(i), 1'b1, 1'b0);
            hits++;
          end
        end
        if (hits > 0) expected_reports[expected_reports.size()-1].last = 1'b1;
      end else begin
        dense_seen++;
      end
      if (hits == 0) queue_report(sparse, 7'(active), 6'd0, 1'b0, 1'b1);
      clear_spectrum();
    endfunction

    function void check_result(bit [15:0] data, bit last);
      band_report_t exp_r;
      bit bad;
      if (expected_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: unexpected result data=%h last=%b", data, last);
        return;
      end
      exp_r = expected_reports[0];
      expected_reports.delete(0);
      reports_checked++;
      bad = (data[0] != exp_r.sparse) || (data[7:1] != exp_r.count)
         || (data[13:8] != exp_r.band) || (data[14] != exp_r.valid) || (last != exp_r.last);
      if (bad) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: sparse/count/band/valid/last expected %b/%0d/%0d/%b/%b",
                    " got %b/%0d/%0d/%b/%b"},
                   exp_r.sparse, exp_r.count, exp_r.band, exp_r.valid, exp_r.last,
                   data[0], data[7:1], data[13:8], data[14], last);
      end
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    function void close_out();
      if (expected_reports.size() != 0) begin
        failures += expected_reports.size();
        $display("mismatch: %0d expected results never came", expected_reports.size());
      end
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [sstc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [sstc_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  // before_level [31:0], after_level [63:32], delta_db [79:64]
  logic [79:0]                     s_axis_tdata;
  logic                            s_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  // is_sparse [0], active_count [7:1], band_index [13:8], band_valid [14]
  logic [15:0]                     m_axis_tdata;
  logic                            m_axis_tlast;

  spectrum_scoreboard sb = new();

  int unsigned bins_sent;
  int unsigned settings_used;
  int unsigned hold_requests;
  bit          idle_on;
  bit          tx_idle;
  bit          rx_idle;

  sparse_spectrum_tone_classifier_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // result side: random stall bursts plus one long hold on demand
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_served;
    stall_left = 0;
    holds_served = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if (hold_requests != holds_served) begin
        holds_served++;
        stall_left = LONG_HOLD;
      end
      if (stall_left == 0 && rx_idle && $urandom_range(0, 4) == 0)
        stall_left = $urandom_range(1, 4);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_bin(input bit [31:0] pre_level, input bit [31:0] post_level,
                          input bit [15:0] delta, input bit final_bin);
    s_axis_tdata  <= {delta, post_level, pre_level};
    s_axis_tlast  <= final_bin;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_bin(pre_level, post_level, delta, final_bin);
    bins_sent++;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [sstc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [sstc_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic write_config(input bit [15:0] af, input bit [15:0] sf, input bit [14:0] dt,
                              input bit [6:0] al, input bit [15:0] pst, input bit [15:0] tst);
    wait_drained();
    put_reg(sstc_pkg::CFG_ACTIVE_FRACTION, af);
    put_reg(sstc_pkg::CFG_SIGNIFICANT_FRACTION, sf);
    put_reg(sstc_pkg::CFG_DELTA_THRESHOLD, 16'(dt));
    put_reg(sstc_pkg::CFG_ACTIVE_LIMIT, 16'(al));
    put_reg(sstc_pkg::CFG_PEAK_SHARE, pst);
    put_reg(sstc_pkg::CFG_TOP4_SHARE, tst);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic write_random_config();
    write_config(16'($urandom), 16'($urandom), 15'($urandom), 7'($urandom_range(0, 64)),
                 16'($urandom), 16'($urandom));
  endtask

  function automatic bit [31:0] pick_level(shape_e shape, bit [31:0] base);
    case (shape)
      SHAPE_TONAL:  return ($urandom_range(0, 7) == 0) ? ($urandom | 32'h0010_0000)
                                                       : 32'($urandom_range(0, 32'hFFFF));
      SHAPE_FLAT:   return base + 32'($urandom_range(0, base >> 3));
      SHAPE_SILENT: return 32'($urandom_range(0, 16));
      default:      return $urandom;
    endcase
  endfunction

  function automatic bit [15:0] pick_delta();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 1200)) - 16'd600;
      default: return 16'($urandom_range(0, 200)) - 16'd100;
    endcase
  endfunction

  task automatic send_spectrum(input int unsigned len, input shape_e shape);
    bit [31:0] base;
    base    = $urandom >> $urandom_range(4, 12);
    tx_idle = idle_on && ($urandom_range(0, 2) != 0);
    rx_idle <= idle_on && ($urandom_range(0, 2) != 0);
    for (int unsigned i = 0; i < len; i++)
      send_bin(pick_level(shape, base), pick_level(shape, base), pick_delta(), i == len - 1);
  endtask

  task automatic random_spectrum();
    int unsigned len;
    int unsigned pick;
    shape_e shape;
    pick = $urandom_range(0, 19);
    if (pick < 12)      len = $urandom_range(1, 12);
    else if (pick < 17) len = $urandom_range(13, 30);
    else if (pick < 19) len = $urandom_range(31, BINS);
    else                len = BINS;
    case ($urandom_range(0, 15))
      0:             shape = SHAPE_SILENT;
      1, 2, 3:       shape = SHAPE_WILD;
      4, 5, 6, 7:    shape = SHAPE_FLAT;
      default:       shape = SHAPE_TONAL;
    endcase
    send_spectrum(len, shape);
  endtask

  task automatic run_random_until(input int unsigned bin_goal);
    while (bins_sent < bin_goal) random_spectrum();
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    bins_sent     = 0;
    settings_used = 0;
    hold_requests <= 0;
    idle_on       = 1'b0;
    tx_idle       = 1'b0;
    rx_idle       <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // silent spectrum, the most negative delta flagged but unused
    send_bin(32'd16, 32'd3, 16'h0000, 1'b0);
    send_bin(32'd0, 32'd16, 16'h8000, 1'b1);
    // one full-scale bin, most positive delta
    send_bin(32'hFFFF_FFFF, 32'd0, 16'h7FFF, 1'b1);
    // equal energies for the top four, delta right at and below threshold
    send_bin(32'h0100_0000, 32'h00FF_FFFF, 16'h0000, 1'b0);
    send_bin(32'h00FF_FFFF, 32'h0100_0000, 16'hFF00, 1'b0);
    send_bin(32'h0100_0000, 32'h0100_0000, 16'h00FF, 1'b0);
    send_bin(32'h0100_0000, 32'h0000_0000, 16'h0100, 1'b0);
    send_bin(32'h0000_0000, 32'h0100_0000, 16'hFF01, 1'b0);
    send_bin(32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b1);

    idle_on = 1'b1;
    run_random_until(70);

    // shares held out of reach: not-sparse summaries, then the floored total
    write_config(sstc_pkg::RST_ACTIVE_FRACTION, sstc_pkg::RST_SIGNIFICANT_FRACTION,
                 sstc_pkg::RST_DELTA_THRESHOLD, 7'd0, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 5; i++) send_bin(32'h0100_0000, 32'h0000_0000, 16'h0000, i == 4);
    for (int i = 0; i < 4; i++) send_bin(32'h0000_1000, 32'h0000_0FFF, 16'h0010, i == 3);
    run_random_until(110);

    write_config(16'h0000, 16'h0000, 15'h0000, 7'd0, 16'h0000, 16'h0000);
    run_random_until(150);

    write_config(16'hFFFF, 16'hFFFF, 15'h7FFF, 7'd64, 16'hFFFF, 16'hFFFF);
    run_random_until(190);

    // results held off while spectra keep coming, so the input backs up
    write_random_config();
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 3; i++) send_spectrum($urandom_range(16, 24), SHAPE_TONAL);
    run_random_until(250);

    // sender waits for every result, then a full and an over-long spectrum
    wait_drained();
    send_spectrum(BINS, SHAPE_WILD);
    send_spectrum(BINS + 3, SHAPE_TONAL);
    run_random_until(320);

    write_config(sstc_pkg::RST_ACTIVE_FRACTION, sstc_pkg::RST_SIGNIFICANT_FRACTION,
                 sstc_pkg::RST_DELTA_THRESHOLD, sstc_pkg::RST_ACTIVE_LIMIT,
                 sstc_pkg::RST_PEAK_SHARE, sstc_pkg::RST_TOP4_SHARE);
    idle_on = 1'b0;
    run_random_until(TARGET_BINS);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    sb.close_out();

    $display("covered %0d bins in %0d spectra under %0d register settings, %0d results checked",
             bins_sent, sb.spectra, settings_used + 1, sb.reports_checked);
    $display("spectra: %0d sparse, %0d not sparse, %0d silent, %0d over-long",
             sb.sparse_seen, sb.dense_seen, sb.silent_seen, sb.overlong_seen);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", sb.failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sstc_pkg.sv
rtl/core/sstc_ctrl.sv
rtl/core/sstc_dp.sv
rtl/core/sparse_spectrum_tone_classifier_unit.sv
bench/tb_sparse_spectrum_tone_classifier_unit.sv
